>>> rtl/core/rgmf_pkg.sv
// rgmf_pkg: shared types and constants of the gated running median filter
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package rgmf_pkg;

	// reading and register widths
	localparam int unsigned MM_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MM = 2'd1;

	// register reset values
	localparam logic [MM_W-1:0] RST_MIN_MM = 16'd30;
	localparam logic [MM_W-1:0] RST_MAX_MM = 16'd2000;

	// status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
	localparam logic [1:0] STATUS_RANGE   = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_STEP,
		S_SEL
	} state_t;

	// strobes from the sequencer to one cell
	typedef struct packed {
		logic wr;
		logic load;
		logic step;
	} cell_ctrl_t;

	// value travelling along the cell ring
	typedef struct packed {
		logic            live;
		logic [MM_W-1:0] value;
	} token_t;

	// one result word
	typedef struct packed {
		logic [MM_W-1:0] filtered_mm;
		logic [1:0]      status;
	} result_t;

endpackage

>>> rtl/core/rgmf_in_if.sv
// rgmf_in_if: input channel carrying one sensor reading word
// depends on rgmf_pkg
`timescale 1ns / 1ps

interface rgmf_in_if import rgmf_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [MM_W-1:0] reading_mm;
	logic            timed_out;

	modport source (output valid, output reading_mm, output timed_out, input ready);
	modport sink (input valid, input reading_mm, input timed_out, output ready);
endinterface

>>> rtl/core/rgmf_out_if.sv
// rgmf_out_if: output channel carrying one filtered result word
// depends on rgmf_pkg
`timescale 1ns / 1ps

interface rgmf_out_if import rgmf_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [MM_W-1:0] filtered_mm;
	logic [1:0]      status;

	modport source (output valid, output filtered_mm, output status, input ready);
	modport sink (input valid, input filtered_mm, input status, output ready);
endinterface

>>> rtl/core/rgmf_cfg_if.sv
// rgmf_cfg_if: register write channel, index plus write data
// depends on rgmf_pkg
`timescale 1ns / 1ps

interface rgmf_cfg_if import rgmf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [MM_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/rgmf_cell.sv
// rgmf_cell: one ring slot; holds a reading and counts how many held readings rank below it
// depends on rgmf_pkg
`timescale 1ns / 1ps

module rgmf_cell import rgmf_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_ctrl_t      ctrl,
	input  logic            live,
	input  logic [CW-1:0]   step_k,
	input  logic [MM_W-1:0] wr_value,
	input  token_t          tok_in,
	output token_t          tok_out,
	output logic [MM_W-1:0] value,
	output logic [CW-1:0]   rank
);

	logic [MM_W-1:0] value_q;
	logic [MM_W-1:0] tok_value_q;
	logic            tok_live_q;
	logic [CW-1:0]   rank_q;
	logic            tie_wins;
	logic            beats;

	// equal values: the token from a lower slot ranks first; at step k it came from slot IDX-k
	assign tie_wins = (step_k != '0) && (step_k <= CW'(IDX));
	assign beats = tok_live_q &&
		((tok_value_q < value_q) || ((tok_value_q == value_q) && tie_wins));

	// control part of the cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_live_q <= 1'b0;
			rank_q <= '0;
		end else if (ctrl.load) begin
			tok_live_q <= live;
			rank_q <= '0;
		end else if (ctrl.step) begin
			tok_live_q <= tok_in.live;
			if (beats) begin
				rank_q <= rank_q + CW'(1);
			end
		end
	end

	// stored reading and travelling value
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			value_q <= wr_value;
		end
		if (ctrl.load) begin
			tok_value_q <= value_q;
		end else if (ctrl.step) begin
			tok_value_q <= tok_in.value;
		end
	end

	assign tok_out.live = tok_live_q;
	assign tok_out.value = tok_value_q;
	assign value = value_q;
	assign rank = rank_q;

endmodule

>>> rtl/core/rgmf_out_buf.sv
// rgmf_out_buf: output register with one skid entry in front of the result channel
// depends on rgmf_pkg and rgmf_out_if
`timescale 1ns / 1ps

module rgmf_out_buf import rgmf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  result_t           push_data,
	output logic              full,
	rgmf_out_if.source        result
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;
	logic    out_free;

	assign pop = out_valid_q && result.ready;
	assign out_free = !out_valid_q || pop;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload; the skid entry always drains into the output register first
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end
		if (push && (!out_free || skid_valid_q)) begin
			skid_q <= push_data;
		end
	end

	assign full = skid_valid_q;
	assign result.valid = out_valid_q;
	assign result.filtered_mm = out_q.filtered_mm;
	assign result.status = out_q.status;

endmodule

>>> rtl/core/gated_running_median_filter.sv
// gated_running_median_filter: range gate, ring of rank-counting cells and result buffer
// depends on rgmf_pkg, the three channel interfaces, rgmf_cell and rgmf_out_buf
`timescale 1ns / 1ps

// channel   dir   word                      moves when
// sample    in    reading_mm, timed_out     sample.valid && sample.ready
// result    out   filtered_mm, status       result.valid && result.ready
// cfg       in    index, data               cfg.valid && cfg.ready (always ready)
//
// a rejected word (timeout or out of range) is pushed into the result buffer in the cycle it is accepted.
// an accepted word passes through write, load, WINDOW ring
// shifts in which every cell compares against every other, then the median select.
// one word is worked on at a time; sample.ready rises again once the sequencer is idle
// and the skid entry is free, so a waiting result does not block the next word.
// reset clears count, slot, last median and registers; ring contents need no clearing.

module gated_running_median_filter import rgmf_pkg::*; #(
	parameter int unsigned WINDOW = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	rgmf_in_if.sink     sample,
	rgmf_out_if.source  result,
	rgmf_cfg_if.sink    cfg
);

	localparam int unsigned CW = $clog2(WINDOW + 1);
	localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	state_t          state_q;
	state_t          state_d;
	logic [MM_W-1:0] min_mm_q;
	logic [MM_W-1:0] max_mm_q;
	logic [IW-1:0]   slot_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   step_q;
	logic [MM_W-1:0] last_median_q;

	logic            range_bad;
	logic            take_ok;
	logic            load;
	logic            step;
	logic            push;
	result_t         push_data;
	logic            buf_full;
	logic            sample_ready;
	logic [MM_W-1:0] median;

	cell_ctrl_t      ctrl [WINDOW];
	token_t          tok [WINDOW];
	logic [MM_W-1:0] cell_value [WINDOW];
	logic [CW-1:0]   cell_rank [WINDOW];
	logic [WINDOW-1:0] live;
	logic [WINDOW-1:0] match;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mm_q <= RST_MIN_MM;
			max_mm_q <= RST_MAX_MM;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_MIN_MM) begin
				min_mm_q <= cfg.data;
			end
			if (cfg.index == CFG_MAX_MM) begin
				max_mm_q <= cfg.data;
			end
		end
	end

	// range gate
	assign range_bad = (sample.reading_mm < min_mm_q) || (sample.reading_mm > max_mm_q);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d = state_q;
		sample_ready = 1'b0;
		take_ok = 1'b0;
		load = 1'b0;
		step = 1'b0;
		push = 1'b0;
		push_data.filtered_mm = last_median_q;
		push_data.status = STATUS_OK;
		case (state_q)
			S_IDLE: begin
				sample_ready = !buf_full;
				if (sample.valid && !buf_full) begin
					if (sample.timed_out) begin
						push = 1'b1;
						push_data.status = STATUS_TIMEOUT;
					end else if (range_bad) begin
						push = 1'b1;
						push_data.status = STATUS_RANGE;
					end else begin
						take_ok = 1'b1;
						state_d = S_LOAD;
					end
				end
			end
			S_LOAD: begin
				load = 1'b1;
				state_d = S_STEP;
			end
			S_STEP: begin
				step = 1'b1;
				if (step_q == CW'(WINDOW - 1)) begin
					state_d = S_SEL;
				end
			end
			S_SEL: begin
				push = 1'b1;
				push_data.filtered_mm = median;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign sample.ready = sample_ready;

	// ring slot, fill count, step counter and last median
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			count_q <= '0;
			step_q <= '0;
			last_median_q <= '0;
		end else begin
			if (take_ok) begin
				if (slot_q == IW'(WINDOW - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + IW'(1);
				end
				if (count_q != CW'(WINDOW)) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (load) begin
				step_q <= '0;
			end else if (step) begin
				step_q <= step_q + CW'(1);
			end
			if (state_q == S_SEL) begin
				last_median_q <= median;
			end
		end
	end

	// ring of cells, each token moves one cell on per step
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		assign live[i] = CW'(i) < count_q;
		assign ctrl[i].wr = take_ok && (slot_q == IW'(i));
		assign ctrl[i].load = load;
		assign ctrl[i].step = step;
		assign match[i] = live[i] && (cell_rank[i] == (count_q >> 1));

		rgmf_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl[i]),
			.live     (live[i]),
			.step_k   (step_q),
			.wr_value (sample.reading_mm),
			.tok_in   (tok[(i + WINDOW - 1) % WINDOW]),
			.tok_out  (tok[i]),
			.value    (cell_value[i]),
			.rank     (cell_rank[i])
		);
	end

	// median pick: the one live cell whose rank is count/2
	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (match[i]) begin
				median = median | cell_value[i];
			end
		end
	end

	rgmf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (buf_full),
		.result    (result)
	);

	// checks
	a_ok_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		take_ok |=> state_q == S_LOAD)
		else $error("accepted reading did not start the rank pass");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WINDOW))
		else $error("fill count above window");

	a_sel_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEL |-> !buf_full)
		else $error("median ready with result buffer full");

	a_single_median: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEL |-> $onehot(match))
		else $error("median select not unique");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STEP |-> step_q < CW'(WINDOW))
		else $error("ring step count overran the window");

endmodule
